/* rtl/core/tree_lca_binary_lifting_macros.svh */
// Assertion macros shared by the tree LCA binary lifting RTL.
`ifndef TREE_LCA_BINARY_LIFTING_MACROS_SVH
`define TREE_LCA_BINARY_LIFTING_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define TLCA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlca: same-cycle check failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define TLCA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tlca: next-cycle check failed");
`else
`define TLCA_ASSERT_IMP(lbl, ante, cons)
`define TLCA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/tlca_pkg.sv */
// Types, constants and helpers for the tree LCA binary lifting block.
package tlca_pkg;

    localparam int NODE_W    = 10;
    localparam int NODES     = 1 << NODE_W;
    localparam int LEVELS    = 11;
    localparam int LEVEL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CNT_W     = $clog2(LEVELS + 1);
    localparam int DEPTH_W   = 10;
    localparam int STEPS_W   = 10;
    localparam int PATH_W    = 11;
    localparam int TBL_DEPTH = NODES * LEVELS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    localparam logic              OP_LOAD  = 1'b0;
    localparam logic              OP_QUERY = 1'b1;
    localparam logic [PATH_W-1:0] NO_PATH  = {PATH_W{1'b1}};

    typedef struct packed {
        logic               op;
        logic [NODE_W-1:0]  node_a;
        logic [NODE_W-1:0]  node_b;
        logic               is_root;
        logic [STEPS_W-1:0] steps;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              ancestor_found;
        logic [NODE_W-1:0] common_ancestor;
        logic [PATH_W-1:0] path_edges;
    } t_out_item;

    // One entry of the lifting table: the 2^j-th ancestor and whether it exists.
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
    } t_tbl_entry;

    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        t_tbl_entry        data;
    } t_tbl_wr;

    typedef struct packed {
        logic               en;
        logic [NODE_W-1:0]  addr;
        logic [DEPTH_W-1:0] data;
    } t_dep_wr;

    // Rows are packed back to back: entry (node, level) sits at node * LEVELS + level.
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [NODE_W-1:0] node,
                                                   input logic [LEVEL_W-1:0] level);
        logic [TBL_AW-1:0] row;
        row = TBL_AW'(node) * TBL_AW'(LEVELS);
        return row + TBL_AW'(level);
    endfunction

endpackage

/* rtl/core/tlca_store.sv */
// Lifting table and depth memories of the tree LCA block, registered read ports.
module tlca_store (
    input  logic                            i_clk,
    input  logic [tlca_pkg::TBL_AW-1:0]     i_tbl_rd_addr_a,
    input  logic [tlca_pkg::TBL_AW-1:0]     i_tbl_rd_addr_b,
    output tlca_pkg::t_tbl_entry            o_tbl_rd_a,
    output tlca_pkg::t_tbl_entry            o_tbl_rd_b,
    input  tlca_pkg::t_tbl_wr               i_tbl_wr,
    input  logic [tlca_pkg::NODE_W-1:0]     i_dep_rd_addr_0,
    input  logic [tlca_pkg::NODE_W-1:0]     i_dep_rd_addr_1,
    output logic [tlca_pkg::DEPTH_W-1:0]    o_dep_rd_0,
    output logic [tlca_pkg::DEPTH_W-1:0]    o_dep_rd_1,
    input  tlca_pkg::t_dep_wr               i_dep_wr
);
    import tlca_pkg::*;

    t_tbl_entry         r_tbl_mem [TBL_DEPTH];
    logic [DEPTH_W-1:0] r_dep_mem [NODES];

    always_ff @(posedge i_clk) begin
        if (i_tbl_wr.en) begin
            r_tbl_mem[i_tbl_wr.addr] <= i_tbl_wr.data;
        end
        o_tbl_rd_a <= r_tbl_mem[i_tbl_rd_addr_a];
        o_tbl_rd_b <= r_tbl_mem[i_tbl_rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_dep_wr.en) begin
            r_dep_mem[i_dep_wr.addr] <= i_dep_wr.data;
        end
        o_dep_rd_0 <= r_dep_mem[i_dep_rd_addr_0];
        o_dep_rd_1 <= r_dep_mem[i_dep_rd_addr_1];
    end

endmodule

/* rtl/core/tree_lca_binary_lifting.sv */
// Binary lifting LCA engine: one transaction at a time; every table read goes through a registered read port.
// A query result sits in an output register, so loads proceed while it waits to be taken.
// Reset (synchronous, active low) clears the sequencer and the output valid; memories keep contents.
`include "tree_lca_binary_lifting_macros.svh"
module tree_lca_binary_lifting (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tlca_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tlca_pkg::t_out_item   o_out_data
);
    import tlca_pkg::*;

    // Sequencer states. Loads walk S_LD*, queries walk S_Q*.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LD0  = 4'd1;   // write level 0 or start a root row
    localparam logic [3:0] S_LDD  = 4'd2;   // parent depth arrives, write own depth
    localparam logic [3:0] S_LDI  = 4'd3;   // issue read of the previous ancestor's row
    localparam logic [3:0] S_LDW  = 4'd4;   // copy the read entry into the new row
    localparam logic [3:0] S_Q0   = 4'd5;   // issue depth reads of both nodes
    localparam logic [3:0] S_QD   = 4'd6;   // depths arrive, start the step climb
    localparam logic [3:0] S_QC   = 4'd7;   // climb: examine one bit of the count
    localparam logic [3:0] S_QCW  = 4'd8;   // climb: take one jump
    localparam logic [3:0] S_QUI  = 4'd9;   // lift both nodes: issue reads
    localparam logic [3:0] S_QUW  = 4'd10;  // lift both nodes: compare and jump
    localparam logic [3:0] S_QFI  = 4'd11;  // issue reads of both parents
    localparam logic [3:0] S_QFW  = 4'd12;  // parents must agree
    localparam logic [3:0] S_QL   = 4'd13;  // issue depth read of the LCA
    localparam logic [3:0] S_QLW  = 4'd14;  // compute the path length
    localparam logic [3:0] S_DONE = 4'd15;  // hand the result to the output register

    logic [3:0]         r_state, n_state;
    logic [NODE_W-1:0]  r_a, n_a;
    logic [NODE_W-1:0]  r_b, n_b;
    logic               r_is_root, n_is_root;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic [CNT_W-1:0]   r_lvl, n_lvl;
    // r_u is the climbing node (and the previous ancestor during a load); r_v the other node.
    logic [NODE_W-1:0]  r_u, n_u;
    logic [NODE_W-1:0]  r_v, n_v;
    logic               r_uok, n_uok;
    logic [STEPS_W-1:0] r_k, n_k;
    logic               r_phase, n_phase;
    logic [DEPTH_W-1:0] r_da, n_da;
    logic [DEPTH_W-1:0] r_db, n_db;
    logic [NODE_W-1:0]  r_anc, n_anc;
    logic               r_found, n_found;
    logic [NODE_W-1:0]  r_lca, n_lca;
    logic [PATH_W-1:0]  r_path, n_path;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [TBL_AW-1:0]  w_tbl_rd_addr_a;
    logic [TBL_AW-1:0]  w_tbl_rd_addr_b;
    t_tbl_entry         w_tbl_rd_a;
    t_tbl_entry         w_tbl_rd_b;
    t_tbl_wr            w_tbl_wr;
    logic [NODE_W-1:0]  w_dep_rd_addr_0;
    logic [DEPTH_W-1:0] w_dep_rd_0;
    logic [DEPTH_W-1:0] w_dep_rd_1;
    t_dep_wr            w_dep_wr;
    logic [CNT_W-1:0]   w_lvl_a;
    logic               w_swap;
    logic [DEPTH_W-1:0] w_diff;
    logic               w_out_free;

    tlca_store u_store (
        .i_clk           (i_clk),
        .i_tbl_rd_addr_a (w_tbl_rd_addr_a),
        .i_tbl_rd_addr_b (w_tbl_rd_addr_b),
        .o_tbl_rd_a      (w_tbl_rd_a),
        .o_tbl_rd_b      (w_tbl_rd_b),
        .i_tbl_wr        (w_tbl_wr),
        .i_dep_rd_addr_0 (w_dep_rd_addr_0),
        .i_dep_rd_addr_1 (r_b),
        .o_dep_rd_0      (w_dep_rd_0),
        .o_dep_rd_1      (w_dep_rd_1),
        .i_dep_wr        (w_dep_wr)
    );

    // During a load the row being copied is one level below the one being written.
    assign w_lvl_a         = (r_state == S_LDI) ? (r_lvl - CNT_W'(1)) : r_lvl;
    assign w_tbl_rd_addr_a = tbl_addr(r_u, w_lvl_a[LEVEL_W-1:0]);
    assign w_tbl_rd_addr_b = tbl_addr(r_v, r_lvl[LEVEL_W-1:0]);
    assign w_dep_rd_addr_0 = (r_state == S_QL) ? r_lca : r_a;

    // The deeper node climbs by the depth difference before both are lifted together.
    assign w_swap = (r_da < r_db);
    assign w_diff = w_swap ? (r_db - r_da) : (r_da - r_db);

    // No transaction is taken while reset is held.
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_is_root   = r_is_root;
        n_steps     = r_steps;
        n_lvl       = r_lvl;
        n_u         = r_u;
        n_v         = r_v;
        n_uok       = r_uok;
        n_k         = r_k;
        n_phase     = r_phase;
        n_da        = r_da;
        n_db        = r_db;
        n_anc       = r_anc;
        n_found     = r_found;
        n_lca       = r_lca;
        n_path      = r_path;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        w_tbl_wr.en   = 1'b0;
        w_tbl_wr.addr = tbl_addr(r_a, r_lvl[LEVEL_W-1:0]);
        w_tbl_wr.data = '0;
        w_dep_wr.en   = 1'b0;
        w_dep_wr.addr = r_a;
        w_dep_wr.data = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a       = i_in_data.node_a;
                    n_b       = i_in_data.node_b;
                    n_is_root = i_in_data.is_root;
                    n_steps   = i_in_data.steps;
                    n_lvl     = '0;
                    n_state   = (i_in_data.op == OP_QUERY) ? S_Q0 : S_LD0;
                end
            end
            S_LD0: begin
                if (r_is_root) begin
                    // A root gets depth zero and a row of empty entries.
                    w_dep_wr.en = 1'b1;
                    n_uok       = 1'b0;
                    n_state     = S_LDI;
                end else begin
                    // The parent's depth is read on port 1 in this cycle.
                    w_tbl_wr.en        = 1'b1;
                    w_tbl_wr.data.valid = 1'b1;
                    w_tbl_wr.data.node  = r_b;
                    n_u     = r_b;
                    n_uok   = 1'b1;
                    n_lvl   = CNT_W'(1);
                    n_state = S_LDD;
                end
            end
            S_LDD: begin
                w_dep_wr.en   = 1'b1;
                w_dep_wr.data = w_dep_rd_1 + DEPTH_W'(1);
                n_state       = S_LDI;
            end
            S_LDI: begin
                if (r_lvl == CNT_W'(LEVELS)) begin
                    n_state = S_IDLE;
                end else if (r_uok) begin
                    n_state = S_LDW;
                end else begin
                    w_tbl_wr.en = 1'b1;
                    n_lvl       = r_lvl + CNT_W'(1);
                end
            end
            S_LDW: begin
                w_tbl_wr.en   = 1'b1;
                w_tbl_wr.data = w_tbl_rd_a;
                n_u           = w_tbl_rd_a.node;
                n_uok         = w_tbl_rd_a.valid;
                n_lvl         = r_lvl + CNT_W'(1);
                n_state       = S_LDI;
            end
            S_Q0: begin
                n_state = S_QD;
            end
            S_QD: begin
                n_da    = w_dep_rd_0;
                n_db    = w_dep_rd_1;
                n_u     = r_a;
                n_k     = r_steps;
                n_uok   = ((r_steps >> LEVELS) == '0);
                n_lvl   = '0;
                n_phase = 1'b0;
                n_state = S_QC;
            end
            S_QC: begin
                if ((r_lvl == CNT_W'(LEVELS)) || !r_uok) begin
                    if (!r_phase) begin
                        // Step climb finished; set up the depth-equalizing climb.
                        n_anc   = r_uok ? r_u : '0;
                        n_found = r_uok;
                        n_u     = w_swap ? r_b : r_a;
                        n_v     = w_swap ? r_a : r_b;
                        n_k     = STEPS_W'(w_diff);
                        n_uok   = ((w_diff >> LEVELS) == '0);
                        n_lvl   = '0;
                        n_phase = 1'b1;
                    end else if (!r_uok) begin
                        n_lca   = '0;
                        n_path  = NO_PATH;
                        n_state = S_DONE;
                    end else if (r_u == r_v) begin
                        n_lca   = r_u;
                        n_state = S_QL;
                    end else begin
                        n_lvl   = CNT_W'(LEVELS - 1);
                        n_state = S_QUI;
                    end
                end else if (r_k[0]) begin
                    n_state = S_QCW;
                end else begin
                    n_k   = r_k >> 1;
                    n_lvl = r_lvl + CNT_W'(1);
                end
            end
            S_QCW: begin
                if (!w_tbl_rd_a.valid) begin
                    n_uok = 1'b0;
                end else begin
                    n_u = w_tbl_rd_a.node;
                end
                n_k     = r_k >> 1;
                n_lvl   = r_lvl + CNT_W'(1);
                n_state = S_QC;
            end
            S_QUI: begin
                n_state = S_QUW;
            end
            S_QUW: begin
                if (w_tbl_rd_a.valid && w_tbl_rd_b.valid &&
                    (w_tbl_rd_a.node != w_tbl_rd_b.node)) begin
                    n_u = w_tbl_rd_a.node;
                    n_v = w_tbl_rd_b.node;
                end
                if (r_lvl == '0) begin
                    n_state = S_QFI;
                end else begin
                    n_lvl   = r_lvl - CNT_W'(1);
                    n_state = S_QUI;
                end
            end
            S_QFI: begin
                n_state = S_QFW;
            end
            S_QFW: begin
                if (w_tbl_rd_a.valid && w_tbl_rd_b.valid &&
                    (w_tbl_rd_a.node == w_tbl_rd_b.node)) begin
                    n_lca   = w_tbl_rd_a.node;
                    n_state = S_QL;
                end else begin
                    n_lca   = '0;
                    n_path  = NO_PATH;
                    n_state = S_DONE;
                end
            end
            S_QL: begin
                n_state = S_QLW;
            end
            S_QLW: begin
                n_path  = PATH_W'(r_da) + PATH_W'(r_db) - (PATH_W'(w_dep_rd_0) << 1);
                n_state = S_DONE;
            end
            S_DONE: begin
                // Wait here only while an earlier result still sits unread.
                if (w_out_free) begin
                    n_out.ancestor        = r_anc;
                    n_out.ancestor_found  = r_found;
                    n_out.common_ancestor = r_lca;
                    n_out.path_edges      = r_path;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_is_root <= n_is_root;
        r_steps   <= n_steps;
        r_lvl     <= n_lvl;
        r_u       <= n_u;
        r_v       <= n_v;
        r_uok     <= n_uok;
        r_k       <= n_k;
        r_phase   <= n_phase;
        r_da      <= n_da;
        r_db      <= n_db;
        r_anc     <= n_anc;
        r_found   <= n_found;
        r_lca     <= n_lca;
        r_path    <= n_path;
        r_out     <= n_out;
    end

    // A load only ever writes into the row of the node being loaded.
    `TLCA_ASSERT_IMP(a_tbl_wr_own_row, w_tbl_wr.en, w_tbl_wr.addr == tbl_addr(r_a, r_lvl[LEVEL_W-1:0]))
    // Queries never modify the lifting table or the depths; checked in S_Q0, S_QC, S_QUW, S_QFW, S_QLW and S_DONE.
    `TLCA_ASSERT_IMP(a_query_no_write, (r_state == S_Q0) || (r_state == S_QC) || (r_state == S_QUW) || (r_state == S_QFW) || (r_state == S_QLW) || (r_state == S_DONE), !w_tbl_wr.en && !w_dep_wr.en)
    // An accepted transaction keeps the engine busy for at least the next cycle.
    `TLCA_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // A new result is only loaded when the output register is free.
    `TLCA_ASSERT_IMP(a_no_result_overrun, (r_state == S_DONE) && r_out_valid && !i_out_ready, n_state == S_DONE)

endmodule
